[src/mssa_pkg.sv]
// ----------------------------------------------------------------------------
// MCMC step-size adapter package
// Shared widths, fixed-point constants, register indexes and the window
// request type.
// ----------------------------------------------------------------------------
package mssa_pkg;

    localparam int WINDOW_LENGTH_DEF = 100;

    localparam int IN_TDATA_W  = 56;   // accepted + log_likelihood, byte padded
    localparam int OUT_TDATA_W = 40;   // 16 + 7 + 1 + 16
    localparam int LL_W        = 48;
    localparam int FACTOR_W    = 17;   // factor can drift above 1.0 on odd gains
    localparam int STEP_W      = 17;   // saturating step count, past any burn-in
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE   = 17'd32768;
    localparam logic [FACTOR_W-1:0] FACTOR_MIN   = 17'd3277;
    localparam logic [FACTOR_W-1:0] FACTOR_INIT  = 17'd6554;
    localparam logic [FACTOR_W-1:0] FACTOR_STUCK = 17'd9830;
    localparam logic [STEP_W-1:0]   STEP_SAT     = 17'd65536;

    localparam logic [15:0] BURNIN_RST    = 16'd200;
    localparam logic [9:0]  INTERVAL_RST  = 10'd10;
    localparam logic [6:0]  LOW_RST       = 7'd23;
    localparam logic [6:0]  HIGH_RST      = 7'd40;
    localparam logic [23:0] TOLERANCE_RST = 24'd6554;
    localparam logic [15:0] STUCK_LIM_RST = 16'd500;
    localparam logic [15:0] INC_GAIN_RST  = 16'd33423;
    localparam logic [15:0] DEC_GAIN_RST  = 16'd32113;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BURNIN    = 3'd0,
        CFG_INTERVAL  = 3'd1,
        CFG_LOW       = 3'd2,
        CFG_HIGH      = 3'd3,
        CFG_TOLERANCE = 3'd4,
        CFG_STUCK_LIM = 3'd5,
        CFG_INC_GAIN  = 3'd6,
        CFG_DEC_GAIN  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic shift;
        logic bit_in;
    } win_req_t;

endpackage

[src/mssa_cell.sv]
// ----------------------------------------------------------------------------
// Window cell
// Holds one accept bit and passes it to the next cell on every request.
// ----------------------------------------------------------------------------
module mssa_cell (
    input  logic aclk,
    input  logic aresetn,
    input  logic shift_en,
    input  logic d,
    output logic q
);

    logic q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= 1'b0;
        end else if (shift_en) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

[src/mssa_window.sv]
// ----------------------------------------------------------------------------
// Accept window
// Chain of one-bit cells holding the last WINDOW_LENGTH accept bits, with a
// running count. The bit leaving the far end is the one dropped from the sum.
// ----------------------------------------------------------------------------
module mssa_window #(
    parameter int WINDOW_LENGTH = mssa_pkg::WINDOW_LENGTH_DEF,
    localparam int SUM_W = $clog2(WINDOW_LENGTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mssa_pkg::win_req_t   req,
    output logic [SUM_W-1:0]     sum_next
);

    logic [WINDOW_LENGTH-1:0] tap;
    logic [SUM_W-1:0]         sum_reg;

    genvar i;
    generate
        for (i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
            if (i == 0) begin : g_head
                mssa_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (req.shift),
                    .d        (req.bit_in),
                    .q        (tap[i])
                );
            end else begin : g_body
                mssa_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (req.shift),
                    .d        (tap[i-1]),
                    .q        (tap[i])
                );
            end
        end
    endgenerate

    assign sum_next = sum_reg - SUM_W'(tap[WINDOW_LENGTH-1]) + SUM_W'(req.bit_in);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (req.shift) begin
            sum_reg <= sum_next;
        end
    end

endmodule

[src/mcmc_step_size_adapter.sv]
// ----------------------------------------------------------------------------
// MCMC step-size adapter
// Tracks acceptance over a sliding window, detects stuck chains and scales
// the proposal step factor. One result per sampler step.
// ----------------------------------------------------------------------------
// An accepted request's result goes to the output register, or to the skid
// entry while the output stalls. Throughput: one request per cycle while
// s_tready is high; the step factor feedback through the gain multiplier and
// clamp is combinational. Output register plus one skid entry: s_tready drops
// only when both hold. Reset (aresetn low, synchronous): window, counters and
// reference cleared, factor back to 0.2, registers to defaults.
// ----------------------------------------------------------------------------
module mcmc_step_size_adapter #(
    parameter int WINDOW_LENGTH = mssa_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // s_tdata: [0] accepted, [48:1] log_likelihood, [55:49] zero
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [mssa_pkg::IN_TDATA_W-1:0]       s_tdata,
    // m_tdata: [15:0] scale factor, [22:16] accept_count,
    //          [23] refresh_proposal, [39:24] reject_run
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mssa_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_wr_en,
    input  logic [mssa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mssa_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int SUM_W = $clog2(WINDOW_LENGTH + 1);
    localparam int CW    = (SUM_W > 7) ? SUM_W : 7;
    localparam int FW    = mssa_pkg::FACTOR_W;
    localparam int LW    = mssa_pkg::LL_W;

    // configuration
    logic [15:0] burnin_reg;
    logic [9:0]  interval_reg;
    logic [6:0]  low_reg;
    logic [6:0]  high_reg;
    logic [23:0] tolerance_reg;
    logic [15:0] stuck_lim_reg;
    logic [15:0] inc_gain_reg;
    logic [15:0] dec_gain_reg;

    // step state
    logic [15:0]                  reject_reg, reject_next;
    logic [mssa_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [9:0]                   adapt_reg, adapt_next, adapt_inc;
    logic [15:0]                  stuck_reg, stuck_next, stuck_hold;
    logic [LW-1:0]                ref_reg, ref_next;
    logic [FW-1:0]                factor_reg, factor_next, factor_mid;

    // output register and skid entry
    logic                         out_valid_reg, skid_valid_reg;
    logic [mssa_pkg::OUT_TDATA_W-1:0] out_data_reg, skid_data_reg, result;

    logic                 accept_in, acc, past_burnin, at_burnin, stuck_hit;
    logic                 grow, shrink, refresh;
    logic [LW-1:0]        ll;
    logic [LW:0]          diff, mag;
    logic [SUM_W-1:0]     sum_next;
    logic [CW-1:0]        sum_cw;
    logic [6:0]           count_out;
    logic [15:0]          gain;
    logic [32:0]          prod_full;
    logic [FW-1:0]        scaled;
    mssa_pkg::win_req_t   win_req;

    assign s_tready  = !skid_valid_reg;
    assign accept_in = s_tvalid && s_tready;
    assign acc       = s_tdata[0];
    assign ll        = s_tdata[LW:1];

    assign win_req.shift  = accept_in;
    assign win_req.bit_in = acc;

    mssa_window #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (win_req),
        .sum_next (sum_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burnin_reg    <= mssa_pkg::BURNIN_RST;
            interval_reg  <= mssa_pkg::INTERVAL_RST;
            low_reg       <= mssa_pkg::LOW_RST;
            high_reg      <= mssa_pkg::HIGH_RST;
            tolerance_reg <= mssa_pkg::TOLERANCE_RST;
            stuck_lim_reg <= mssa_pkg::STUCK_LIM_RST;
            inc_gain_reg  <= mssa_pkg::INC_GAIN_RST;
            dec_gain_reg  <= mssa_pkg::DEC_GAIN_RST;
        end else if (cfg_wr_en) begin
            unique case (mssa_pkg::cfg_index_t'(cfg_index))
                mssa_pkg::CFG_BURNIN:    burnin_reg    <= cfg_wdata[15:0];
                mssa_pkg::CFG_INTERVAL:  interval_reg  <= cfg_wdata[9:0];
                mssa_pkg::CFG_LOW:       low_reg       <= cfg_wdata[6:0];
                mssa_pkg::CFG_HIGH:      high_reg      <= cfg_wdata[6:0];
                mssa_pkg::CFG_TOLERANCE: tolerance_reg <= cfg_wdata;
                mssa_pkg::CFG_STUCK_LIM: stuck_lim_reg <= cfg_wdata[15:0];
                mssa_pkg::CFG_INC_GAIN:  inc_gain_reg  <= cfg_wdata[15:0];
                mssa_pkg::CFG_DEC_GAIN:  dec_gain_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // one step: reject run, stuck detect, stuck reset, adaptation
    always_comb begin
        reject_next = acc ? 16'd0
                    : ((reject_reg != 16'hFFFF) ? reject_reg + 16'd1 : reject_reg);
        step_next   = (step_reg == mssa_pkg::STEP_SAT) ? step_reg
                                                       : step_reg + 1'b1;

        past_burnin = step_reg >  {1'b0, burnin_reg};
        at_burnin   = step_reg >= {1'b0, burnin_reg};

        diff      = {ll[LW-1], ll} - {ref_reg[LW-1], ref_reg};
        mag       = diff[LW] ? (~diff + 1'b1) : diff;
        stuck_hit = past_burnin && (mag < (LW+1)'(tolerance_reg));

        if (stuck_hit) begin
            stuck_hold = (stuck_reg != 16'hFFFF) ? stuck_reg + 16'd1 : stuck_reg;
            ref_next   = ref_reg;
        end else begin
            stuck_hold = 16'd0;
            ref_next   = ll;
        end

        factor_mid = factor_reg;
        stuck_next = stuck_hold;
        refresh    = 1'b0;
        if (stuck_hold > stuck_lim_reg && factor_reg > mssa_pkg::FACTOR_MIN) begin
            factor_mid = mssa_pkg::FACTOR_STUCK;
            stuck_next = 16'd0;
            refresh    = 1'b1;
        end

        sum_cw     = CW'(sum_next);
        adapt_inc  = adapt_reg + 10'd1;
        adapt_next = adapt_reg;
        grow       = 1'b0;
        shrink     = 1'b0;
        if (at_burnin) begin
            adapt_next = adapt_inc;
            if (adapt_inc >= interval_reg) begin
                adapt_next = 10'd0;
                grow   = (sum_cw > CW'(high_reg)) && (factor_mid < mssa_pkg::FACTOR_ONE);
                shrink = !grow && (sum_cw < CW'(low_reg))
                         && (factor_mid > mssa_pkg::FACTOR_MIN);
            end
        end

        // product wraps at 32 bits before the Q1.15 shift
        gain      = grow ? inc_gain_reg : dec_gain_reg;
        prod_full = {16'd0, factor_mid} * {17'd0, gain};
        scaled    = prod_full[31:15];

        factor_next = factor_mid;
        if (grow) begin
            factor_next = (scaled > mssa_pkg::FACTOR_ONE) ? mssa_pkg::FACTOR_ONE : scaled;
            refresh     = 1'b1;
        end else if (shrink) begin
            factor_next = (scaled < mssa_pkg::FACTOR_MIN) ? mssa_pkg::FACTOR_MIN : scaled;
            refresh     = 1'b1;
        end

        count_out = (sum_cw > CW'(127)) ? 7'd127 : 7'(sum_cw);
        result    = {reject_next, refresh, count_out, factor_next[15:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reject_reg <= '0;
            step_reg   <= '0;
            adapt_reg  <= '0;
            stuck_reg  <= '0;
            ref_reg    <= '0;
            factor_reg <= mssa_pkg::FACTOR_INIT;
        end else if (accept_in) begin
            reject_reg <= reject_next;
            step_reg   <= step_next;
            adapt_reg  <= adapt_next;
            stuck_reg  <= stuck_next;
            ref_reg    <= ref_next;
            factor_reg <= factor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg  <= skid_valid_reg || accept_in;
            skid_valid_reg <= 1'b0;
        end else if (accept_in) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end else if (accept_in) begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[src/mssa_checker.sv]
// ----------------------------------------------------------------------------
// MCMC step-size adapter checker
// Port-level checks on reset, output stall behavior and skid occupancy.
// ----------------------------------------------------------------------------
module mssa_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mssa_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("state not empty after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input backpressure only with a result waiting
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with output empty");

    // a full skid entry stays full while the output stalls
    a_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && !m_tready |=> !s_tready)
        else $error("skid entry lost under stall");

    // a request taken with the output empty shows up on the next cycle
    a_take_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
        else $error("accepted request did not reach the output");

endmodule

bind mcmc_step_size_adapter mssa_checker u_mssa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
